// ===== sv/ptd_pkg.sv =====
package ptd_pkg;

   // Width of the candidate field on the request port.
   localparam int CAND_W = 32;

   // Trial divisors follow the 6k +/- 1 pattern starting at FIRST_DIV.
   localparam int FIRST_DIV = 5;
   localparam int DIV_STEP  = 6;
   localparam int PAIR_GAP  = 2;
   localparam int SMALL_DIV = 3;

   // Largest value that is not prime, and largest value that is prime
   // without any trial.
   localparam int LAST_NONPRIME = 1;
   localparam int LAST_TRIVIAL  = 3;

   // Running square of the trial divisor: (i + 6)^2 = i^2 + 12i + 36.
   localparam int FIRST_SQ  = FIRST_DIV * FIRST_DIV;
   localparam int FIRST_INC = 2 * DIV_STEP * FIRST_DIV + DIV_STEP * DIV_STEP;
   localparam int INC_STEP  = 2 * DIV_STEP * DIV_STEP;

   // Status reported by the remainder unit to the sequencer.
   typedef struct packed {
      logic done;   // remainder is final in this cycle
      logic zero;   // remainder equals zero
   } ptd_rem_status_type;

endpackage

// ===== sv/ptd_rem_unit.sv =====
module ptd_rem_unit
   import ptd_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WIDTH-1:0]   dividend,
   input  logic [WIDTH-1:0]   divisor,
   output ptd_rem_status_type status
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] shift_ff, shift_in;
   logic [WIDTH-1:0] div_ff, div_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [WIDTH:0]   trial;

   // One dividend bit enters the partial remainder per cycle, MSB first.
   always_comb begin
      shift_in = shift_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      trial    = {rem_ff, shift_ff[WIDTH-1]};
      if (start) begin
         shift_in = dividend;
         div_in   = divisor;
         rem_in   = '0;
         cnt_in   = CNT_W'(WIDTH);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            if (trial >= {1'b0, div_ff}) begin
               trial = trial - {1'b0, div_ff};
            end
            rem_in   = trial[WIDTH-1:0];
            shift_in = {shift_ff[WIDTH-2:0], 1'b0};
            cnt_in   = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign status.done = busy_ff && (cnt_ff == '0);
   assign status.zero = (rem_ff == '0);

endmodule

// ===== sv/primality_trial_division.sv =====
// Trial-division primality tester. Each request transaction carries one
// unsigned candidate, of which the low WIDTH bits are examined, and each
// produces exactly one response transaction whose flag is 1 when that value
// is prime. Values below 2 are not prime, 2 and 3 are prime, even values are
// composite, and otherwise the value is divided by 3 and then by the pairs
// i and i+2 for i = 5, 11, 17, ... for as long as i*i does not exceed it.
// Every remainder comes from one shared restoring remainder unit that takes
// one dividend bit per cycle, and the sequencer checks the bound once per
// divisor pair in a state of its own. The block works on one candidate at a
// time; a finished result sits in an output register, so a new request is
// taken while the previous response is still stalled. No state survives
// between transactions.
module primality_trial_division
   import ptd_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CAND_W-1:0] req_candidate,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_prime_flag
);

   // The running square may pass the candidate by up to one divisor step
   // before the search stops, so it carries four guard bits.
   localparam int SQ_W = WIDTH + 4;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCREEN = 7'b0000010,
      ST_DIV3   = 7'b0000100,
      ST_BOUND  = 7'b0001000,
      ST_DIVA   = 7'b0010000,
      ST_DIVB   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } ptd_state_type;

   ptd_state_type      state_ff, state_in;
   logic [WIDTH-1:0]   n_ff, n_in;
   logic [WIDTH-1:0]   i_ff, i_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [SQ_W-1:0]    inc_ff, inc_in;
   logic               result_ff, result_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_flag_ff, rsp_flag_in;
   logic [WIDTH-1:0]   cand_masked;
   logic               rem_start;
   logic [WIDTH-1:0]   rem_divisor;
   ptd_rem_status_type rem_status;

   // Only the low WIDTH bits of the candidate take part in the test.
   generate
      if (WIDTH <= CAND_W) begin : g_trunc
         assign cand_masked = req_candidate[WIDTH-1:0];
      end else begin : g_extend
         assign cand_masked = {{(WIDTH - CAND_W){1'b0}}, req_candidate};
      end
   endgenerate

   ptd_rem_unit #(
      .WIDTH (WIDTH)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (n_ff),
      .divisor  (rem_divisor),
      .status   (rem_status)
   );

   // Sequencer: screen the trivial cases, try 3, then walk the divisor
   // pairs while the running square i*i stays at or below the candidate.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      sq_in        = sq_ff;
      inc_in       = inc_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_flag_in  = rsp_flag_ff;
      rem_start    = 1'b0;
      rem_divisor  = WIDTH'(SMALL_DIV);

      // The consumer took the pending response.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in     = cand_masked;
               state_in = ST_SCREEN;
            end
         end
         ST_SCREEN: begin
            if (n_ff <= WIDTH'(LAST_NONPRIME)) begin
               result_in = 1'b0;
               state_in  = ST_FINISH;
            end else if (n_ff <= WIDTH'(LAST_TRIVIAL)) begin
               result_in = 1'b1;
               state_in  = ST_FINISH;
            end else if (!n_ff[0]) begin
               result_in = 1'b0;
               state_in  = ST_FINISH;
            end else begin
               rem_start   = 1'b1;
               rem_divisor = WIDTH'(SMALL_DIV);
               state_in    = ST_DIV3;
            end
         end
         ST_DIV3: begin
            if (rem_status.done) begin
               if (rem_status.zero) begin
                  result_in = 1'b0;
                  state_in  = ST_FINISH;
               end else begin
                  i_in     = WIDTH'(FIRST_DIV);
                  sq_in    = SQ_W'(FIRST_SQ);
                  inc_in   = SQ_W'(FIRST_INC);
                  state_in = ST_BOUND;
               end
            end
         end
         ST_BOUND: begin
            if (sq_ff > {{(SQ_W - WIDTH){1'b0}}, n_ff}) begin
               result_in = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               rem_start   = 1'b1;
               rem_divisor = i_ff;
               state_in    = ST_DIVA;
            end
         end
         ST_DIVA: begin
            if (rem_status.done) begin
               if (rem_status.zero) begin
                  result_in = 1'b0;
                  state_in  = ST_FINISH;
               end else begin
                  rem_start   = 1'b1;
                  rem_divisor = i_ff + WIDTH'(PAIR_GAP);
                  state_in    = ST_DIVB;
               end
            end
         end
         ST_DIVB: begin
            if (rem_status.done) begin
               if (rem_status.zero) begin
                  result_in = 1'b0;
                  state_in  = ST_FINISH;
               end else begin
                  i_in     = i_ff + WIDTH'(DIV_STEP);
                  sq_in    = sq_ff + inc_ff;
                  inc_in   = inc_ff + SQ_W'(INC_STEP);
                  state_in = ST_BOUND;
               end
            end
         end
         ST_FINISH: begin
            // Hand the verdict to the output register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      i_ff        <= i_in;
      sq_ff       <= sq_in;
      inc_ff      <= inc_in;
      result_ff   <= result_in;
      rsp_flag_ff <= rsp_flag_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A new transaction is taken only when the sequencer is free.
   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prime_flag = rsp_flag_ff;

endmodule
